### rtl/core/scalar_kalman_filter_top_macros.svh
// ----------------------------------------------------------------------------
// scalar kalman filter assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_TOP_MACROS_SVH
`define SCALAR_KALMAN_FILTER_TOP_MACROS_SVH

// consequent checked in the same cycle
`define SKF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SKF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// shared constants and types of the scalar kalman filter
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int FIELD_W   = 32;
  localparam int GAIN_W    = 17;
  localparam int GAIN_FRAC = 16;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

  localparam logic [1:0] KIND_PREDICT = 2'd0;
  localparam logic [1:0] KIND_UPDATE  = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_VALUE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_VARIANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_VARIANCE = 2'd2;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

### rtl/core/skf_in_if.sv
// ----------------------------------------------------------------------------
// skf_in_if
// input item channel: kind, measurement value and measurement variance
// ----------------------------------------------------------------------------
interface skf_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [skf_pkg::FIELD_W-1:0]  meas_value;
  logic [skf_pkg::FIELD_W-1:0]  meas_variance;

  modport source (output valid, kind, meas_value, meas_variance, input ready);
  modport sink   (input valid, kind, meas_value, meas_variance, output ready);
endinterface

### rtl/core/skf_out_if.sv
// ----------------------------------------------------------------------------
// skf_out_if
// result channel: estimate, estimate variance and gain
// ----------------------------------------------------------------------------
interface skf_out_if;
  logic                         valid;
  logic                         ready;
  logic [skf_pkg::FIELD_W-1:0]  estimate;
  logic [skf_pkg::FIELD_W-1:0]  estimate_variance;
  logic [skf_pkg::GAIN_W-1:0]   gain;

  modport source (output valid, estimate, estimate_variance, gain, input ready);
  modport sink   (input valid, estimate, estimate_variance, gain, output ready);
endinterface

### rtl/core/skf_cfg_if.sv
// ----------------------------------------------------------------------------
// skf_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface skf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [skf_pkg::CFG_IDX_W-1:0]  index;
  logic [skf_pkg::FIELD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/scalar_kalman_filter_top.sv
// sequence: restart and unused kind go straight to S_OUT, predict via S_PRED, update
// via S_SUM, S_DIV, S_INNOV, S_ABS, S_MULE, S_RNDE, S_APPE, S_CPLV, S_MULV, S_RNDV
// (S_SUM straight to S_OUT when P+R is zero); S_OUT waits while out_if stalls a result
// throughput: one item at a time; update time is set by the 17-step divider
// and two 17-step shift-add multiplies, all on the one shared adder
// reset: synchronous active-low rst_n; estimate 0, variance one, registers to defaults
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top
// scalar kalman filter: predict, measurement update and restart on a small
// sequencer driving one shared adder for division, multiplication and updates
// ----------------------------------------------------------------------------
`include "scalar_kalman_filter_top_macros.svh"

module scalar_kalman_filter_top #(
  parameter int DW = 32
) (
  input logic      clk,
  input logic      rst_n,
  skf_in_if.sink   in_if,
  skf_out_if.source out_if,
  skf_cfg_if.sink  cfg_if
);

  localparam int W  = DW + 18;
  localparam int XW = (DW > 32) ? DW + 1 : 33;
  localparam int MW = DW + 1;
  localparam int FW = skf_pkg::FIELD_W;
  localparam int GW = skf_pkg::GAIN_W;
  localparam int GF = skf_pkg::GAIN_FRAC;

  localparam logic signed [XW-1:0] SMAX_X  = {{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [XW-1:0] SMIN_X  = ~SMAX_X;
  localparam logic        [XW-1:0] UMAX_X  = {{(XW-DW){1'b0}}, {DW{1'b1}}};
  localparam logic signed [XW-1:0] OSMAX_X = {{(XW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [XW-1:0] OSMIN_X = ~OSMAX_X;
  localparam logic        [XW-1:0] OUMAX_X = {{(XW-32){1'b0}}, {32{1'b1}}};
  localparam logic        [XW-1:0] ONE_X   = XW'(65536);
  localparam logic        [DW-1:0] VAR_RESET =
    (ONE_X > UMAX_X) ? UMAX_X[DW-1:0] : ONE_X[DW-1:0];
  localparam logic [W-1:0] ROUND_HALF = {{(W-GF){1'b0}}, 1'b1, {(GF-1){1'b0}}};
  localparam logic [skf_pkg::CNT_W-1:0] CNT_TOP = skf_pkg::CNT_W'(GF);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_PRED  = 13'b0000000000010,
    S_SUM   = 13'b0000000000100,
    S_DIV   = 13'b0000000001000,
    S_INNOV = 13'b0000000010000,
    S_ABS   = 13'b0000000100000,
    S_MULE  = 13'b0000001000000,
    S_RNDE  = 13'b0000010000000,
    S_APPE  = 13'b0000100000000,
    S_CPLV  = 13'b0001000000000,
    S_MULV  = 13'b0010000000000,
    S_RNDV  = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  function automatic logic [DW-1:0] sat_s(input logic [FW-1:0] v);
    logic signed [XW-1:0] x;
    logic        [DW-1:0] r;
    x = signed'({{(XW-FW){v[FW-1]}}, v});
    if (x > SMAX_X) begin
      r = SMAX_X[DW-1:0];
    end else if (x < SMIN_X) begin
      r = SMIN_X[DW-1:0];
    end else begin
      r = x[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] sat_u(input logic [FW-1:0] v);
    logic [XW-1:0] x;
    x = {{(XW-FW){1'b0}}, v};
    return (x > UMAX_X) ? UMAX_X[DW-1:0] : x[DW-1:0];
  endfunction

  function automatic logic [FW-1:0] out_s(input logic [DW-1:0] v);
    logic signed [XW-1:0] x;
    logic        [FW-1:0] r;
    x = signed'({{(XW-DW){v[DW-1]}}, v});
    if (x > OSMAX_X) begin
      r = OSMAX_X[FW-1:0];
    end else if (x < OSMIN_X) begin
      r = OSMIN_X[FW-1:0];
    end else begin
      r = x[FW-1:0];
    end
    return r;
  endfunction

  function automatic logic [FW-1:0] out_u(input logic [DW-1:0] v);
    logic [XW-1:0] x;
    x = {{(XW-DW){1'b0}}, v};
    return (x > OUMAX_X) ? OUMAX_X[FW-1:0] : x[FW-1:0];
  endfunction

  state_t state_r, state_nxt;
  logic [DW-1:0] est_r, est_nxt;
  logic [DW-1:0] var_r, var_nxt;
  logic [FW-1:0] init_val_r, init_var_r, proc_var_r;
  logic [DW-1:0] z_r, z_nxt;
  logic [DW-1:0] r_r, r_nxt;
  logic [DW:0]   s_r, s_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [MW-1:0] mcand_r, mcand_nxt;
  logic [GW-1:0] gain_r, gain_nxt;
  logic [GW-1:0] mul_r, mul_nxt;
  logic [skf_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [FW-1:0] out_est_r, out_est_nxt;
  logic [FW-1:0] out_var_r, out_var_nxt;
  logic [GW-1:0] out_gain_r, out_gain_nxt;

  logic             in_fire, out_fire, cfg_fire;
  skf_pkg::alu_op_t alu_op;
  logic [W-1:0]     alu_a, alu_b, alu_res;
  logic             alu_co;
  logic [W-1:0]     div_trial;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  assign cfg_fire = cfg_if.valid && cfg_if.ready;

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid             = out_valid_r;
  assign out_if.estimate          = out_est_r;
  assign out_if.estimate_variance = out_var_r;
  assign out_if.gain              = out_gain_r;

  assign div_trial = (cnt_r == CNT_TOP) ? rem_r : {rem_r[W-2:0], 1'b0};

  skf_alu #(.W(W)) u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .carry (alu_co)
  );

  // operand selection for the shared adder
  always_comb begin
    alu_op = skf_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state_r)
      S_PRED: begin
        alu_a = {{(W-DW){1'b0}}, var_r};
        alu_b = {{(W-FW){1'b0}}, proc_var_r};
      end
      S_SUM: begin
        alu_a = {{(W-DW){1'b0}}, var_r};
        alu_b = {{(W-DW){1'b0}}, r_r};
      end
      S_DIV: begin
        alu_op = skf_pkg::ALU_SUB;
        alu_a  = div_trial;
        alu_b  = {{(W-DW-1){1'b0}}, s_r};
      end
      S_INNOV: begin
        alu_op = skf_pkg::ALU_SUB;
        alu_a  = {{(W-DW){z_r[DW-1]}}, z_r};
        alu_b  = {{(W-DW){est_r[DW-1]}}, est_r};
      end
      S_ABS: begin
        if (acc_r[W-1]) begin
          alu_op = skf_pkg::ALU_SUB;
          alu_b  = acc_r;
        end else begin
          alu_a = acc_r;
        end
      end
      S_MULE, S_MULV: begin
        alu_a = {acc_r[W-2:0], 1'b0};
        alu_b = mul_r[GW-1] ? {{(W-MW){1'b0}}, mcand_r} : '0;
      end
      S_RNDE, S_RNDV: begin
        alu_a = acc_r;
        alu_b = ROUND_HALF;
      end
      S_APPE: begin
        alu_op = neg_r ? skf_pkg::ALU_SUB : skf_pkg::ALU_ADD;
        alu_a  = {{(W-DW){est_r[DW-1]}}, est_r};
        alu_b  = acc_r;
      end
      S_CPLV: begin
        alu_op = skf_pkg::ALU_SUB;
        alu_a  = {{(W-GW){1'b0}}, skf_pkg::GAIN_ONE};
        alu_b  = {{(W-GW){1'b0}}, gain_r};
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    est_nxt       = est_r;
    var_nxt       = var_r;
    z_nxt         = z_r;
    r_nxt         = r_r;
    s_nxt         = s_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    gain_nxt      = gain_r;
    mul_nxt       = mul_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    out_est_nxt   = out_est_r;
    out_var_nxt   = out_var_r;
    out_gain_nxt  = out_gain_r;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          gain_nxt = '0;
          z_nxt    = sat_s(in_if.meas_value);
          r_nxt    = sat_u(in_if.meas_variance);
          case (in_if.kind)
            skf_pkg::KIND_PREDICT: state_nxt = S_PRED;
            skf_pkg::KIND_UPDATE:  state_nxt = S_SUM;
            skf_pkg::KIND_RESTART: begin
              est_nxt   = sat_s(init_val_r);
              var_nxt   = sat_u(init_var_r);
              state_nxt = S_OUT;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_PRED: begin
        var_nxt   = (alu_res[W-1:DW] != '0) ? '1 : alu_res[DW-1:0];
        state_nxt = S_OUT;
      end
      S_SUM: begin
        s_nxt   = alu_res[DW:0];
        rem_nxt = {{(W-DW){1'b0}}, var_r};
        cnt_nxt = CNT_TOP;
        // zero denominator leaves gain at zero and the estimate and variance as they are
        state_nxt = (alu_res[DW:0] == '0) ? S_OUT : S_DIV;
      end
      S_DIV: begin
        rem_nxt  = alu_co ? alu_res : div_trial;
        gain_nxt = {gain_r[GW-2:0], alu_co};
        if (cnt_r == '0) begin
          state_nxt = S_INNOV;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_INNOV: begin
        acc_nxt   = alu_res;
        neg_nxt   = alu_res[W-1];
        state_nxt = S_ABS;
      end
      S_ABS: begin
        mcand_nxt = alu_res[MW-1:0];
        acc_nxt   = '0;
        mul_nxt   = gain_r;
        cnt_nxt   = CNT_TOP;
        state_nxt = S_MULE;
      end
      S_MULE, S_MULV: begin
        acc_nxt = alu_res;
        mul_nxt = {mul_r[GW-2:0], 1'b0};
        if (cnt_r == '0) begin
          state_nxt = (state_r == S_MULE) ? S_RNDE : S_RNDV;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_RNDE: begin
        acc_nxt   = {{GF{1'b0}}, alu_res[W-1:GF]};
        state_nxt = S_APPE;
      end
      S_APPE: begin
        est_nxt   = alu_res[DW-1:0];
        state_nxt = S_CPLV;
      end
      S_CPLV: begin
        mul_nxt   = alu_res[GW-1:0];
        mcand_nxt = {1'b0, var_r};
        acc_nxt   = '0;
        cnt_nxt   = CNT_TOP;
        state_nxt = S_MULV;
      end
      S_RNDV: begin
        var_nxt   = alu_res[GF +: DW];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_est_nxt   = out_s(est_r);
          out_var_nxt   = out_u(var_r);
          out_gain_nxt  = gain_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      est_r       <= '0;
      var_r       <= VAR_RESET;
      gain_r      <= '0;
      out_valid_r <= 1'b0;
      init_val_r  <= '0;
      init_var_r  <= 32'd65536;
      proc_var_r  <= 32'd655;
    end else begin
      state_r     <= state_nxt;
      est_r       <= est_nxt;
      var_r       <= var_nxt;
      gain_r      <= gain_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        case (cfg_if.index)
          skf_pkg::CFG_INIT_VALUE:    init_val_r <= cfg_if.data;
          skf_pkg::CFG_INIT_VARIANCE: init_var_r <= cfg_if.data;
          skf_pkg::CFG_PROC_VARIANCE: proc_var_r <= cfg_if.data;
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    z_r        <= z_nxt;
    r_r        <= r_nxt;
    s_r        <= s_nxt;
    rem_r      <= rem_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mul_r      <= mul_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    out_est_r  <= out_est_nxt;
    out_var_r  <= out_var_nxt;
    out_gain_r <= out_gain_nxt;
  end

  `SKF_ASSERT_SAME(a_gain_range, 1'b1, gain_r <= skf_pkg::GAIN_ONE, "gain above one")
  `SKF_ASSERT_NEXT(a_accept_busy, in_fire, state_r != S_IDLE, "idle after input transfer")
  `SKF_ASSERT_NEXT(a_var_shrinks, state_r == S_RNDV, var_r <= $past(mcand_r[DW-1:0]), "update grew variance")
  `SKF_ASSERT_SAME(a_out_from_seq, $rose(out_valid_r), $past(state_r) == S_OUT, "result without sequencer")

endmodule

### rtl/core/skf_alu.sv
// ----------------------------------------------------------------------------
// skf_alu
// shared add / subtract unit with carry out (carry set on subtract: a >= b)
// ----------------------------------------------------------------------------
module skf_alu #(
  parameter int W = 50
) (
  input  skf_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     res,
  output logic             carry
);

  logic         is_sub;
  logic [W-1:0] b_eff;
  logic [W:0]   full;

  assign is_sub = (op == skf_pkg::ALU_SUB);
  assign b_eff  = is_sub ? ~b : b;
  assign full   = {1'b0, a} + {1'b0, b_eff} + (W+1)'(is_sub);
  assign res    = full[W-1:0];
  assign carry  = full[W];

endmodule
